FILE: hdl/hfla_pkg.sv
`default_nettype none

package hfla_pkg;

   localparam int MAX_NAMES_DEF = 64;
   localparam int GROW_STEP_DEF = 4;

   localparam logic [1:0] OP_CREATE = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_ERASE  = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic finish;
      logic grow_start;
      logic grow_write;
      logic grow_finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       list_empty;
      logic       has_room;
      logic       slot_free;
      logic       grow_last;
   } status_type;

endpackage

`default_nettype wire

FILE: hdl/handle_free_list_allocator.sv
`default_nettype none

// Handle allocator: hands out nonzero names (entry index plus one) from a
// last-in, first-out free list kept in an internal link memory, one
// operation per request word (create, query, erase, clear) and exactly one
// response word per request. Query, erase, clear and a create from a
// non-empty list read the link memory, then act on the registered read
// data. A create that finds the list empty links in a new block of
// GROW_STEP entries, one memory write a cycle, the last held until the
// response slot is free, and returns the first entry of that block; past
// MAX_NAMES it fails with rsp_out_of_space. A create with a zero object
// handle returns a name that never tests live. A new request is taken once
// the previous one is done, even while its response waits on rsp_ready.

module handle_free_list_allocator
   import hfla_pkg::*;
#(
   parameter int MAX_NAMES = MAX_NAMES_DEF,
   parameter int GROW_STEP = GROW_STEP_DEF,
   localparam int IDX_W = $clog2(MAX_NAMES + 1)
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [1:0]       req_operation,
   input  wire logic [7:0]       req_name_in,
   input  wire logic [31:0]      req_object_handle,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [IDX_W-1:0]      rsp_name_out,
   output logic                  rsp_is_live,
   output logic                  rsp_out_of_space
);

   cmd_type    cmd;
   status_type sts;

   hfla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   hfla_dp #(
      .MAX_NAMES (MAX_NAMES),
      .GROW_STEP (GROW_STEP)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_operation),
      .req_name_in       (req_name_in),
      .req_object_handle (req_object_handle),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_name_out      (rsp_name_out),
      .rsp_is_live       (rsp_is_live),
      .rsp_out_of_space  (rsp_out_of_space)
   );

endmodule

`default_nettype wire

FILE: hdl/hfla_ctrl.sv
`default_nettype none

module hfla_ctrl
   import hfla_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type sts,
   output cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_GROW
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // empty list with room left: link in a fresh block first
            if (sts.op == OP_CREATE && sts.list_empty && sts.has_room) begin
               cmd.grow_start = 1'b1;
               state_in       = ST_GROW;
            end else if (sts.slot_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_GROW: begin
            if (!sts.grow_last) begin
               cmd.grow_write = 1'b1;
            end else if (sts.slot_free) begin
               cmd.grow_write  = 1'b1;
               cmd.grow_finish = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/hfla_dp.sv
`default_nettype none

module hfla_dp
   import hfla_pkg::*;
#(
   parameter int MAX_NAMES = MAX_NAMES_DEF,
   parameter int GROW_STEP = GROW_STEP_DEF,
   localparam int IDX_W = $clog2(MAX_NAMES + 1)
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cmd_type          cmd,
   output status_type            sts,
   input  wire logic [1:0]       req_operation,
   input  wire logic [7:0]       req_name_in,
   input  wire logic [31:0]      req_object_handle,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [IDX_W-1:0]      rsp_name_out,
   output logic                  rsp_is_live,
   output logic                  rsp_out_of_space
);

   localparam int ADDR_W = $clog2(MAX_NAMES);
   localparam int CMP_W  = (IDX_W > 8) ? IDX_W : 8;
   localparam int SUM_W  = $clog2(MAX_NAMES + GROW_STEP + 1);
   localparam int CNT_W  = (GROW_STEP > 1) ? $clog2(GROW_STEP) : 1;
   localparam logic [IDX_W-1:0] END_MARK = IDX_W'(MAX_NAMES);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GROW_STEP - 1);

   // entry word: {used, next link}
   logic [IDX_W:0]       mem [MAX_NAMES];
   logic [IDX_W:0]       rd_ff;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_wa;
   logic [IDX_W:0]       mem_wd;
   logic [ADDR_W-1:0]    rd_addr;

   logic [1:0]           op_ff;
   logic [7:0]           name_ff;
   logic                 obj_nz_ff;
   logic [IDX_W-1:0]     head_ff;
   logic [IDX_W-1:0]     head_in;
   logic [IDX_W-1:0]     cap_ff;
   logic [IDX_W-1:0]     cap_in;
   logic [CNT_W-1:0]     cnt_ff;
   logic [CNT_W-1:0]     cnt_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [IDX_W-1:0]     rsp_name_ff;
   logic                 rsp_live_ff;
   logic                 rsp_oos_ff;

   logic [CMP_W-1:0]     req_name_m1;
   logic [CMP_W-1:0]     name_m1;
   logic                 in_range;
   logic                 rd_used;
   logic [IDX_W-1:0]     rd_link;
   logic                 list_empty;
   logic                 has_room;
   logic                 pop_ok;
   logic                 erase_ok;
   logic [IDX_W-1:0]     grow_idx;
   logic [IDX_W-1:0]     grow_link;
   logic [IDX_W-1:0]     grow_head;
   logic [IDX_W-1:0]     erase_idx;

   assign req_name_m1 = CMP_W'(req_name_in) - CMP_W'(1);
   assign name_m1     = CMP_W'(name_ff) - CMP_W'(1);
   assign erase_idx   = name_m1[IDX_W-1:0];
   assign in_range    = (name_ff != 8'd0) && (CMP_W'(name_ff) <= CMP_W'(cap_ff));
   assign rd_used     = rd_ff[IDX_W];
   assign rd_link     = rd_ff[IDX_W-1:0];
   assign list_empty  = (head_ff >= cap_ff);
   assign has_room    = (SUM_W'(cap_ff) + SUM_W'(GROW_STEP)) <= SUM_W'(MAX_NAMES);
   assign pop_ok      = (op_ff == OP_CREATE) && !list_empty;
   assign erase_ok    = (op_ff == OP_ERASE) && in_range && rd_used;

   assign grow_idx    = cap_ff + IDX_W'(cnt_ff);
   assign grow_link   = (cnt_ff == CNT_LAST) ? END_MARK : grow_idx + IDX_W'(1);
   // first entry of a new block is handed out at once, so the head skips it
   assign grow_head   = (GROW_STEP > 1) ? cap_ff + IDX_W'(1) : END_MARK;

   assign rd_addr = (req_operation == OP_CREATE) ? head_ff[ADDR_W-1:0]
                                                 : req_name_m1[ADDR_W-1:0];

   always_comb begin
      mem_we = 1'b0;
      mem_wa = grow_idx[ADDR_W-1:0];
      mem_wd = {(cnt_ff == '0) & obj_nz_ff, grow_link};
      if (cmd.grow_write) begin
         mem_we = 1'b1;
      end else if (cmd.finish && pop_ok) begin
         mem_we = 1'b1;
         mem_wa = head_ff[ADDR_W-1:0];
         mem_wd = {obj_nz_ff, rd_link};
      end else if (cmd.finish && erase_ok) begin
         mem_we = 1'b1;
         mem_wa = erase_idx[ADDR_W-1:0];
         mem_wd = {1'b0, head_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (cmd.accept) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= req_operation;
         name_ff   <= req_name_in;
         obj_nz_ff <= |req_object_handle;
      end
   end

   always_comb begin
      head_in = head_ff;
      cap_in  = cap_ff;
      if (cmd.grow_finish) begin
         head_in = grow_head;
         cap_in  = IDX_W'(SUM_W'(cap_ff) + SUM_W'(GROW_STEP));
      end else if (cmd.finish) begin
         case (op_ff)
            OP_CREATE: begin
               if (pop_ok) begin
                  head_in = rd_link;
               end
            end
            OP_ERASE: begin
               if (erase_ok) begin
                  head_in = erase_idx;
               end
            end
            OP_CLEAR: begin
               head_in = END_MARK;
               cap_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.grow_start) begin
         cnt_in = '0;
      end else if (cmd.grow_write && !cmd.grow_finish) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish || cmd.grow_finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= END_MARK;
         cap_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         cap_ff       <= cap_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.grow_finish) begin
         rsp_name_ff <= cap_ff + IDX_W'(1);
         rsp_live_ff <= 1'b0;
         rsp_oos_ff  <= 1'b0;
      end else if (cmd.finish) begin
         rsp_name_ff <= pop_ok ? head_ff + IDX_W'(1) : '0;
         rsp_live_ff <= (op_ff == OP_QUERY) && in_range && rd_used;
         rsp_oos_ff  <= (op_ff == OP_CREATE) && list_empty;
      end
   end

   assign sts.op         = op_ff;
   assign sts.list_empty = list_empty;
   assign sts.has_room   = has_room;
   assign sts.slot_free  = !rsp_valid_ff || rsp_ready;
   assign sts.grow_last  = (cnt_ff == CNT_LAST);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_name_out     = rsp_name_ff;
   assign rsp_is_live      = rsp_live_ff;
   assign rsp_out_of_space = rsp_oos_ff;

   a_cap_bound: assert property (@(posedge clock) disable iff (reset)
      cap_ff <= END_MARK)
      else $error("capacity above limit");

   a_head_sane: assert property (@(posedge clock) disable iff (reset)
      (head_ff == END_MARK) || (head_ff < cap_ff))
      else $error("free head outside capacity");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && op_ff == OP_CLEAR) |=> (cap_ff == '0 && head_ff == END_MARK))
      else $error("clear left state behind");

   a_grow_result: assert property (@(posedge clock) disable iff (reset)
      cmd.grow_finish |=> (rsp_valid_ff && !rsp_oos_ff && rsp_name_ff != '0))
      else $error("growth gave no name");

endmodule

`default_nettype wire
